[rtl/usad_pkg.sv]
// Package for the UPDI SYNC autobaud detector.
// Widths, event codes, sequence positions and the result/queue types.
// No dependencies.
package usad_pkg;

    localparam int LEN_BITS = 32;
    localparam int POS_BITS = 48;
    localparam int PH_BITS  = 4;
    localparam int Q_DEPTH  = 2;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int Q_CW     = $clog2(Q_DEPTH + 1);

    localparam logic [PH_BITS-1:0] PH_IDLE = PH_BITS'(0);
    localparam logic [PH_BITS-1:0] PH_BIT1 = PH_BITS'(1);
    localparam logic [PH_BITS-1:0] PH_BIT8 = PH_BITS'(8);
    localparam logic [PH_BITS-1:0] PH_BIT9 = PH_BITS'(9);

    typedef enum logic [2:0] {
        EV_START  = 3'd0,
        EV_IDLE   = 3'd1,
        EV_WRONG  = 3'd2,
        EV_NARROW = 3'd3,
        EV_WIDE   = 3'd4,
        EV_RATE   = 3'd5,
        EV_SYNC   = 3'd6
    } t_event;

    typedef struct packed {
        t_event               ev;
        logic [POS_BITS-1:0]  position;
        logic [LEN_BITS-1:0]  rate;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/updi_sync_autobaud_detector.sv]
// UPDI SYNC autobaud detector, top level. One line run is taken per clock
// while the result queue has room; a run that causes a result writes it into
// the queue at its accepting edge, and it passes from there into the output
// register, which drives the output channel. The sustained rate is one run
// per cycle, limited only by output stalls once the two-entry queue and the
// output register are full; input ready then returns after the first result
// drains. The front end holds the sequence position and measured bit width;
// the width checks of a run are combinational compares of twice its length
// against 1x and 3x the expected width.
// Uses usad_pkg, usad_front, usad_fifo and usad_back.
module updi_sync_autobaud_detector
    import usad_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_level,
    input  logic [POS_BITS-1:0] i_run_start,
    input  logic [LEN_BITS-1:0] i_run_length,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [2:0]          o_event_res,
    output logic [POS_BITS-1:0] o_position,
    output logic [LEN_BITS-1:0] o_rate_value
);

    logic      accept;
    logic      push;
    logic      pop;
    t_result   front_res;
    t_result   q_data;
    t_result   out_data;
    t_q_status q_status;

    assign o_in_ready = !q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    usad_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_level      (i_level),
        .i_run_start  (i_run_start),
        .i_run_length (i_run_length),
        .o_push       (push),
        .o_result     (front_res)
    );

    usad_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_res),
        .i_pop    (pop),
        .o_data   (q_data),
        .o_status (q_status)
    );

    usad_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_data   (q_data),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (out_data)
    );

    assign o_event_res  = out_data.ev;
    assign o_position   = out_data.position;
    assign o_rate_value = out_data.rate;

endmodule

[rtl/usad_front.sv]
// Front end: accepts line runs, tracks the SYNC sequence and classifies runs.
// Pushes at most one result per run into the result queue. Uses usad_pkg.
module usad_front
    import usad_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_level,
    input  logic [POS_BITS-1:0] i_run_start,
    input  logic [LEN_BITS-1:0] i_run_length,
    output logic                o_push,
    output t_result             o_result
);

    logic                r_first;
    logic                n_first;
    logic [PH_BITS-1:0]  r_pos;
    logic [PH_BITS-1:0]  n_pos;
    logic [LEN_BITS-1:0] r_width;
    logic [LEN_BITS-1:0] n_width;
    logic [POS_BITS-1:0] r_sync_begin;
    logic [POS_BITS-1:0] n_sync_begin;

    logic [LEN_BITS:0]   expw;
    logic [LEN_BITS+1:0] len2;
    logic [LEN_BITS+2:0] exp3;
    logic                want;
    logic                wrong;
    logic                narrow;
    logic                wide;
    logic                bad;
    t_event              bad_ev;

    // expected width: one bit in bits one to seven, two bits afterwards
    assign expw   = (r_pos >= PH_BIT8) ? {r_width, 1'b0} : {1'b0, r_width};
    assign len2   = {1'b0, i_run_length, 1'b0};
    assign exp3   = {2'b00, expw} + {1'b0, expw, 1'b0};
    assign want   = (r_pos < PH_BIT8) ? r_pos[0] : (r_pos != PH_BIT8);
    assign wrong  = (i_level != want);
    assign narrow = (len2 < {1'b0, expw});
    assign wide   = ({1'b0, len2} > exp3);
    assign bad    = wrong || narrow || wide;
    assign bad_ev = wrong ? EV_WRONG : (narrow ? EV_NARROW : EV_WIDE);

    always_comb begin
        n_first           = r_first;
        n_pos             = r_pos;
        n_width           = r_width;
        n_sync_begin      = r_sync_begin;
        o_push            = 1'b0;
        o_result.ev       = EV_IDLE;
        o_result.position = i_run_start;
        o_result.rate     = '0;
        if (i_accept) begin
            n_first = 1'b1;
            if (!r_first && !i_level) begin
                o_push      = 1'b1;
                o_result.ev = EV_START;
            end else if (r_pos == PH_IDLE) begin
                if (!i_level) begin
                    n_sync_begin = i_run_start;
                    n_width      = i_run_length;
                    n_pos        = PH_BIT1;
                end else begin
                    o_push      = 1'b1;
                    o_result.ev = EV_IDLE;
                end
            end else if (bad) begin
                n_pos        = PH_IDLE;
                n_sync_begin = '0;
                o_push       = 1'b1;
                o_result.ev  = bad_ev;
            end else if (r_pos < PH_BIT8) begin
                n_pos = r_pos + PH_BIT1;
            end else if (r_pos == PH_BIT8) begin
                n_pos         = PH_BIT9;
                o_push        = 1'b1;
                o_result.ev   = EV_RATE;
                o_result.rate = r_width;
            end else begin
                n_pos             = PH_IDLE;
                n_sync_begin      = '0;
                o_push            = 1'b1;
                o_result.ev       = EV_SYNC;
                o_result.position = r_sync_begin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first      <= 1'b0;
            r_pos        <= PH_IDLE;
            r_width      <= '0;
            r_sync_begin <= '0;
        end else begin
            r_first      <= n_first;
            r_pos        <= n_pos;
            r_width      <= n_width;
            r_sync_begin <= n_sync_begin;
        end
    end

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PH_BIT9)
        else $error("sequence position out of range");

    a_rate_only_event5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_result.ev != EV_RATE) |-> (o_result.rate == '0))
        else $error("rate reported outside bit 8-9 event");

    a_sync_after_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (o_result.ev == EV_SYNC) |-> (r_pos == PH_BIT9))
        else $error("sync reported without preceding bit 8-9");
`endif

endmodule

[rtl/usad_fifo.sv]
// Small result queue between the front end and the output stage.
// Flip-flop storage, one push and one pop port. Uses usad_pkg.
module usad_fifo
    import usad_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    input  logic      i_pop,
    output t_result   o_data,
    output t_q_status o_status
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_CW-1:0]    r_count;
    logic [Q_AW-1:0]    n_wr;
    logic [Q_AW-1:0]    n_rd;
    logic [Q_CW-1:0]    n_count;

    assign o_data         = r_mem[r_rd];
    assign o_status.full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_status.full))
        else $error("push into full result queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("pop from empty result queue");
`endif

endmodule

[rtl/usad_back.sv]
// Output stage: drains the result queue into a registered output channel.
// Uses usad_pkg.
module usad_back
    import usad_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_result   i_q_data,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_data
);

    logic    r_valid;
    logic    n_valid;
    t_result r_data;

    assign o_pop   = !i_q_status.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_q_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |-> !o_pop)
        else $error("output register overwritten while stalled");
`endif

endmodule
